>>> design/dbpg_pkg.sv
// Shared types, constants and helper functions for the De Bruijn pattern generator.
// No dependencies; every other design file except dbpg_ram imports this package.
package dbpg_pkg;

  // Field and register widths
  localparam int ORDER_DEF    = 3;
  localparam int MAX_ALPHABET = 64;
  localparam int SYM_W        = 6;
  localparam int CHAR_W       = 8;
  localparam int ALPHA_W      = 7;
  localparam int CNT_W        = 21;
  localparam int MODE_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 21;
  localparam int QUEUE_DEPTH  = 2;

  // Register reset values
  localparam logic [ALPHA_W-1:0] ALPHA_RST   = 7'd62;
  localparam logic [CNT_W-1:0]   OFFSET_RST  = 21'd0;
  localparam logic [CNT_W-1:0]   PAT_LEN_RST = 21'd4096;

  // Request codes on the input channel
  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NEXT    = 2'd2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHABET_SIZE  = 2'd0,
    CFG_START_OFFSET   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2
  } cfg_reg_t;

  // Decoded command held in the queue
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_RESTART,
    CMD_NEXT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [SYM_W-1:0]  idx;
    logic [CHAR_W-1:0] chr;
  } cmd_t;

  // Configuration bundle handed to the back end
  typedef struct packed {
    logic [ALPHA_W-1:0] alphabet_size;
    logic [CNT_W-1:0]   start_offset;
    logic [CNT_W-1:0]   pattern_length;
  } cfg_regs_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SUCC,
    ST_SKIP
  } back_state_t;

  // Default charset: upper case, lower case, then 1..9 and 0, rest zero
  function automatic logic [CHAR_W-1:0] default_char(logic [SYM_W-1:0] idx);
    logic [CHAR_W-1:0] wide;
    wide = {2'b00, idx};
    if (idx < 6'd26) begin
      return CHAR_W'(wide + 8'h41);
    end else if (idx < 6'd52) begin
      return CHAR_W'(wide - 8'd26 + 8'h61);
    end else if (idx < 6'd61) begin
      return CHAR_W'(wide - 8'd52 + 8'h31);
    end else if (idx == 6'd61) begin
      return 8'h30;
    end else begin
      return '0;
    end
  endfunction

endpackage

>>> design/dbpg_ifs.sv
// Channel interfaces of the De Bruijn pattern generator: request, result, configuration.
// Depends on dbpg_pkg for field widths.
interface dbpg_in_if import dbpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SYM_W-1:0]  charset_index;
  logic [CHAR_W-1:0] charset_char;

  modport source (output valid, mode, charset_index, charset_char, input ready);
  modport sink   (input valid, mode, charset_index, charset_char, output ready);
endinterface

interface dbpg_out_if import dbpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic [SYM_W-1:0]  symbol_index;
  logic              exhausted;
  logic              is_last;

  modport source (output valid, out_char, symbol_index, exhausted, is_last, input ready);
  modport sink   (input valid, out_char, symbol_index, exhausted, is_last, output ready);
endinterface

interface dbpg_cfg_if import dbpg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/dbpg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dbpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

>>> design/dbpg_front.sv
// Front end: takes request transactions and decodes them into queue commands.
// Depends on dbpg_pkg and dbpg_in_if.
module dbpg_front
  import dbpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dbpg_in_if.sink     in_chan,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic known;

  // Accept whenever the queue has room
  assign in_chan.ready = !q_full;

  // Classify the request; drop the unused code
  always_comb begin
    known        = 1'b1;
    q_cmd.op     = CMD_NEXT;
    q_cmd.idx    = in_chan.charset_index;
    q_cmd.chr    = in_chan.charset_char;
    unique case (in_chan.mode)
      MODE_LOAD:    q_cmd.op = CMD_LOAD;
      MODE_RESTART: q_cmd.op = CMD_RESTART;
      MODE_NEXT:    q_cmd.op = CMD_NEXT;
      default:      known    = 1'b0;
    endcase
  end

  assign q_push = in_chan.valid && in_chan.ready && known;

`ifndef SYNTHESIS
  // A push never lands on a full queue
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("push into full queue");
`endif

endmodule

>>> design/dbpg_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on dbpg_pkg for the command type and depth.
module dbpg_queue
  import dbpg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_QW'(QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CNT_QW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CNT_QW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  // Never pop an empty queue
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> valid)
    else $error("pop from empty queue");
`endif

endmodule

>>> design/dbpg_back.sv
// Back end: runs charset loads, restarts with skip and character requests.
// Holds the prenecklace walker, the charset RAM and the result register.
// Depends on dbpg_pkg, dbpg_out_if and dbpg_ram.
module dbpg_back
  import dbpg_pkg::*;
#(
  parameter int ORDER = ORDER_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  input  cfg_regs_t  cfg,
  dbpg_out_if.source out_chan
);

  localparam int POS_W = $clog2(ORDER + 1);

  back_state_t        state_r, state_nxt;
  logic [SYM_W-1:0]   pn_r [1:ORDER];
  logic [SYM_W-1:0]   pn_nxt [1:ORDER];
  logic [POS_W-1:0]   wl_r, wl_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   skip_r, skip_nxt;
  logic               ret_skip_r, ret_skip_nxt;
  logic [MAX_ALPHABET-1:0] vld_r, vld_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic [SYM_W-1:0]   out_sym_r, out_sym_nxt;
  logic               out_exh_r, out_exh_nxt;
  logic               out_last_r, out_last_nxt;

  logic [SYM_W-1:0]   top;
  logic [SYM_W-1:0]   cur_sym;
  logic               succ_found;
  logic [POS_W-1:0]   succ_i;
  logic [SYM_W-1:0]   succ_pn [1:ORDER];
  logic [ORDER:1]     div_mask;
  logic               div_hit;
  logic [POS_W:0]     pos_inc;
  logic               step_stays;
  logic               exhausted_now;
  logic               out_free;
  logic               skip_end;
  logic [CNT_W-1:0]   cnt_inc;
  logic               ram_we;
  logic [CHAR_W-1:0]  ram_q;

  // Charset storage; entries never written read as the default table
  dbpg_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_ALPHABET)
  ) u_charset (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_cmd.idx),
    .wdata (q_cmd.chr),
    .raddr (cur_sym),
    .rdata (ram_q)
  );

  // Word lengths that divide the order
  for (genvar Len = 1; Len <= ORDER; Len++) begin : g_div
    assign div_mask[Len] = ((ORDER % Len) == 0);
  end

  // Top symbol of the clamped alphabet
  always_comb begin
    if (cfg.alphabet_size == '0) begin
      top = '0;
    end else if (cfg.alphabet_size > ALPHA_W'(MAX_ALPHABET)) begin
      top = SYM_W'(MAX_ALPHABET - 1);
    end else begin
      top = SYM_W'(cfg.alphabet_size - 1'b1);
    end
  end

  // Symbol at the current emit position
  always_comb begin
    cur_sym = pn_r[1];
    for (int k = 1; k <= ORDER; k++) begin
      if (pos_r == POS_W'(k)) begin
        cur_sym = pn_r[k];
      end
    end
  end

  // Duval successor: bump the last non-maximal symbol, repeat the prefix after it
  always_comb begin
    succ_found = 1'b0;
    succ_i     = '0;
    div_hit    = 1'b0;
    for (int k = 1; k <= ORDER; k++) begin
      if (pn_r[k] < top) begin
        succ_found = 1'b1;
        succ_i     = POS_W'(k);
      end
    end
    for (int j = 1; j <= ORDER; j++) begin
      succ_pn[j] = pn_r[j];
      if (succ_i == POS_W'(j)) begin
        succ_pn[j] = SYM_W'(pn_r[j] + 1'b1);
      end
      for (int k = 1; k < j; k++) begin
        if (succ_i == POS_W'(j - k)) begin
          succ_pn[j] = succ_pn[k];
        end
      end
    end
    for (int k = 1; k <= ORDER; k++) begin
      if (succ_i == POS_W'(k)) begin
        div_hit = div_mask[k];
      end
    end
  end

  assign pos_inc       = {1'b0, pos_r} + 1'b1;
  assign step_stays    = (pos_inc <= {1'b0, wl_r});
  assign exhausted_now = done_r || (count_r >= cfg.pattern_length);
  assign out_free      = !out_valid_r || out_chan.ready;
  assign skip_end      = (skip_r >= cfg.start_offset) || done_r;
  assign cnt_inc       = CNT_W'(count_r + 1'b1);

  // Pop the head command once it can be served
  assign q_pop  = (state_r == ST_IDLE) && q_valid && ((q_cmd.op != CMD_NEXT) || out_free);
  assign ram_we = q_pop && (q_cmd.op == CMD_LOAD);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          unique case (q_cmd.op)
            CMD_RESTART: state_nxt = ST_SKIP;
            CMD_NEXT:    state_nxt = exhausted_now ? ST_IDLE : ST_FETCH;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FETCH: state_nxt = step_stays ? ST_IDLE : ST_SUCC;
      ST_SUCC: begin
        if (!succ_found || div_hit) begin
          state_nxt = ret_skip_r ? ST_SKIP : ST_IDLE;
        end
      end
      ST_SKIP: begin
        if (skip_end) begin
          state_nxt = ST_IDLE;
        end else if (!step_stays) begin
          state_nxt = ST_SUCC;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates per state
  always_comb begin
    pn_nxt        = pn_r;
    wl_nxt        = wl_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    done_nxt      = done_r;
    skip_nxt      = skip_r;
    ret_skip_nxt  = ret_skip_r;
    vld_nxt       = vld_r;
    sym_nxt       = sym_r;
    out_char_nxt  = out_char_r;
    out_sym_nxt   = out_sym_r;
    out_exh_nxt   = out_exh_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          unique case (q_cmd.op)
            CMD_LOAD: vld_nxt[q_cmd.idx] = 1'b1;
            CMD_RESTART: begin
              // Rewind the walker
              for (int k = 1; k <= ORDER; k++) begin
                pn_nxt[k] = '0;
              end
              wl_nxt       = POS_W'(1);
              pos_nxt      = POS_W'(1);
              count_nxt    = '0;
              done_nxt     = 1'b0;
              skip_nxt     = '0;
              ret_skip_nxt = 1'b1;
            end
            default: begin
              if (exhausted_now) begin
                out_valid_nxt = 1'b1;
                out_char_nxt  = '0;
                out_sym_nxt   = '0;
                out_exh_nxt   = 1'b1;
                out_last_nxt  = 1'b0;
              end else begin
                sym_nxt      = cur_sym;
                ret_skip_nxt = 1'b0;
              end
            end
          endcase
        end
      end
      ST_FETCH: begin
        // Deliver the character and take the first advance step
        out_valid_nxt = 1'b1;
        out_char_nxt  = vld_r[sym_r] ? ram_q : default_char(sym_r);
        out_sym_nxt   = sym_r;
        out_exh_nxt   = 1'b0;
        out_last_nxt  = (cnt_inc == cfg.pattern_length);
        count_nxt     = cnt_inc;
        if (step_stays) begin
          pos_nxt = pos_inc[POS_W-1:0];
        end
      end
      ST_SUCC: begin
        if (!succ_found) begin
          done_nxt = 1'b1;
        end else begin
          pn_nxt = succ_pn;
          wl_nxt = succ_i;
          if (div_hit) begin
            pos_nxt = POS_W'(1);
          end
        end
      end
      ST_SKIP: begin
        if (!skip_end) begin
          skip_nxt = CNT_W'(skip_r + 1'b1);
          if (step_stays) begin
            pos_nxt = pos_inc[POS_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      for (int k = 1; k <= ORDER; k++) begin
        pn_r[k] <= '0;
      end
      wl_r        <= POS_W'(1);
      pos_r       <= POS_W'(1);
      count_r     <= '0;
      done_r      <= 1'b0;
      skip_r      <= '0;
      ret_skip_r  <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pn_r        <= pn_nxt;
      wl_r        <= wl_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      done_r      <= done_nxt;
      skip_r      <= skip_nxt;
      ret_skip_r  <= ret_skip_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    out_char_r <= out_char_nxt;
    out_sym_r  <= out_sym_nxt;
    out_exh_r  <= out_exh_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.out_char     = out_char_r;
  assign out_chan.symbol_index = out_sym_r;
  assign out_chan.exhausted    = out_exh_r;
  assign out_chan.is_last      = out_last_r;

`ifndef SYNTHESIS
  // The successor walk only runs on a live sequence
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == ST_SUCC) |-> !done_r)
    else $error("successor walk after sequence end");

  // At rest the emit position lies inside the current word
  assert property (@(posedge clk) disable iff (!rst_n)
      ((state_r == ST_IDLE) && !done_r) |-> ((pos_r != '0) && (pos_r <= wl_r)))
    else $error("emit position outside word");

  // A charset fetch is always issued from idle
  assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == ST_FETCH) |-> ($past(state_r) == ST_IDLE))
    else $error("fetch without request");

  // A character result never overwrites one still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == ST_FETCH) |-> (!out_valid_r || out_chan.ready))
    else $error("result register overrun");
`endif

endmodule

>>> design/de_bruijn_pattern_generator.sv
// De Bruijn pattern generator, order ORDER (FKM order) over a loadable charset.
// Channels: in_chan takes requests (mode 0 loads charset_char at charset_index,
// mode 1 rewinds and skips start_offset characters, mode 2 asks for the next
// character, mode 3 is dropped). out_chan returns one transaction per mode 2
// request: out_char, symbol_index, exhausted and is_last. cfg_chan writes the
// registers alphabet_size (0), start_offset (1) and pattern_length (2); it is
// always ready and must be used only while the block is idle.
// A character request passes through the command queue, the pop with its charset read
// and the fetch state into the result register; an exhausted reply skips the fetch
// state, as it needs no charset read. The back end serves one request at a time: after
// a pop it takes no further one until the registered charset read is fetched and any
// prenecklace successor walk at the end of a word is done. A restart rewinds and skips
// start_offset characters, stopping early when the sequence ends during the skip.
// Reset: synchronous, active low; registers and charset return to defaults
// (letters then digits) and the walker rewinds. A stalled receiver holds the
// result register; up to two further requests queue before in_chan.ready drops.
// Depends on dbpg_pkg, the channel interfaces, dbpg_front, dbpg_queue and dbpg_back.
module de_bruijn_pattern_generator
  import dbpg_pkg::*;
#(
  parameter int ORDER = ORDER_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dbpg_in_if.sink    in_chan,
  dbpg_out_if.source out_chan,
  dbpg_cfg_if.sink   cfg_chan
);

  cfg_regs_t cfg_r;
  logic      q_push;
  cmd_t      q_push_cmd;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  cmd_t      q_head;

  // Configuration writes are always accepted and land directly in the registers
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alphabet_size  <= ALPHA_RST;
      cfg_r.start_offset   <= OFFSET_RST;
      cfg_r.pattern_length <= PAT_LEN_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_reg_t'(cfg_chan.index))
        CFG_ALPHABET_SIZE:  cfg_r.alphabet_size  <= cfg_chan.data[ALPHA_W-1:0];
        CFG_START_OFFSET:   cfg_r.start_offset   <= cfg_chan.data[CNT_W-1:0];
        CFG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_chan.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  dbpg_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_push_cmd)
  );

  dbpg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  dbpg_back #(
    .ORDER (ORDER)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_head),
    .q_pop    (q_pop),
    .cfg      (cfg_r),
    .out_chan (out_chan)
  );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the De Bruijn pattern generator: directed corner cases, then random
// phases of charset loads, restarts and character requests, checked against an in-bench walker.
// Depends on dbpg_pkg, the channel interfaces and de_bruijn_pattern_generator.
module tb_top;
  import dbpg_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int COUNT_MAX   = 1048576;
  localparam int IDLE_LIMIT  = 50000;
  localparam int ITEM_TARGET = 750;
  localparam int CALM_FROM   = 620;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [SYM_W-1:0]  idx;
    logic [CHAR_W-1:0] chr;
  } request_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [SYM_W-1:0]  sym;
    logic              exh;
    logic              last;
  } char_result_t;

  logic clk;
  logic rst_n;

  dbpg_in_if  in_if ();
  dbpg_out_if out_if ();
  dbpg_cfg_if cfg_if ();

  de_bruijn_pattern_generator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  // Walker copy: registers, charset and prenecklace state
  logic [ALPHA_W-1:0] alpha_reg;
  logic [CNT_W-1:0]   skip_reg;
  logic [CNT_W-1:0]   length_reg;
  logic [CHAR_W-1:0]  charset_mem [MAX_ALPHABET];
  logic [SYM_W-1:0]   prenecklace [ORDER_DEF+1];
  int                 word_len;
  int                 emit_pos;
  logic [CNT_W-1:0]   emit_cnt;
  bit                 seq_end;

  request_t     pending_reqs [$];
  char_result_t expected_chars [$];

  bit idle_on = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int n_items = 0;
  int n_chars = 0;
  int n_exh = 0;
  int n_last = 0;
  int n_phases = 0;
  int n_fail = 0;

  function automatic int symbols_of(logic [ALPHA_W-1:0] a);
    if (a == 0) return 1;
    if (a > MAX_ALPHABET) return MAX_ALPHABET;
    return int'(a);
  endfunction

  function automatic void rewind_walker();
    for (int i = 0; i <= ORDER_DEF; i++) prenecklace[i] = '0;
    word_len = 1;
    emit_pos = 1;
    emit_cnt = '0;
    seq_end  = 1'b0;
  endfunction

  // Duval successor; symbols at or above the top count as maximal
  function automatic bit next_word();
    int top;
    int i;
    top = symbols_of(alpha_reg) - 1;
    i = ORDER_DEF;
    while (i >= 1 && int'(prenecklace[i]) >= top) i--;
    if (i == 0) return 1'b0;
    prenecklace[i] = prenecklace[i] + 1'b1;
    for (int j = i + 1; j <= ORDER_DEF; j++) prenecklace[j] = prenecklace[j-i];
    word_len = i;
    return 1'b1;
  endfunction

  // Advance to the next emitted symbol, skipping words whose length does not divide the order
  function automatic void step_walker();
    if (seq_end) return;
    emit_pos++;
    if (emit_pos <= word_len) return;
    while (1) begin
      if (!next_word()) begin
        seq_end = 1'b1;
        return;
      end
      if (ORDER_DEF % word_len == 0) begin
        emit_pos = 1;
        return;
      end
    end
  endfunction

  function automatic void pattern_step(request_t r);
    char_result_t res;
    int pos;
    case (r.mode)
      MODE_LOAD: charset_mem[r.idx] = r.chr;
      MODE_RESTART: begin
        rewind_walker();
        for (int n = 0; n < int'(skip_reg) && !seq_end; n++) step_walker();
      end
      MODE_NEXT: begin
        if (seq_end || emit_cnt >= length_reg) begin
          res = '{ch: '0, sym: '0, exh: 1'b1, last: 1'b0};
        end else begin
          pos = (emit_pos < 1 || emit_pos > ORDER_DEF) ? 1 : emit_pos;
          emit_cnt = emit_cnt + 1'b1;
          res.sym  = prenecklace[pos];
          res.ch   = charset_mem[res.sym];
          res.exh  = 1'b0;
          res.last = (emit_cnt == length_reg);
          step_walker();
        end
        expected_chars.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%h, actual 0x%h", $time, what, want, got);
      n_fail++;
    end
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Request driver: hold each transaction until accepted, insert random gaps
  always @(posedge clk) begin : req_driver
    request_t cur;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        cur.mode = in_if.mode;
        cur.idx  = in_if.charset_index;
        cur.chr  = in_if.charset_char;
        pattern_step(cur);
        void'(pending_reqs.pop_front());
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_reqs.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 17);
          in_if.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_if.valid         <= 1'b1;
          in_if.mode          <= pending_reqs[0].mode;
          in_if.charset_index <= pending_reqs[0].idx;
          in_if.charset_char  <= pending_reqs[0].chr;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transaction with the oldest expected character
  always @(posedge clk) begin : char_monitor
    char_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t ns: unexpected transaction, expected none, actual char 0x%h sym %0d",
                   $time, out_if.out_char, out_if.symbol_index);
          $display("%0t ns: unexpected transaction flags, exh %b last %b",
                   $time, out_if.exhausted, out_if.is_last);
          n_fail++;
        end else begin
          want = expected_chars.pop_front();
          n_chars++;
          if (want.exh) n_exh++;
          if (want.last) n_last++;
          check_field("out_char", want.ch, out_if.out_char);
          check_field("symbol_index", 8'(want.sym), 8'(out_if.symbol_index));
          check_field("exhausted", 8'(want.exh), 8'(out_if.exhausted));
          check_field("is_last", 8'(want.last), 8'(out_if.is_last));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_req(logic [MODE_W-1:0] m, logic [SYM_W-1:0] i = '0,
                           logic [CHAR_W-1:0] c = '0);
    request_t r;
    r = '{mode: m, idx: i, chr: c};
    pending_reqs.push_back(r);
    if (m != MODE_UNUSED) n_items++;
  endtask

  // Wait for every request to be taken and every character returned, then let the walker settle
  task automatic wait_idle();
    @(posedge clk);
    while (pending_reqs.size() != 0 || expected_chars.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Write the selected registers back to back; call at a rising edge while idle
  task automatic configure(bit wa, logic [ALPHA_W-1:0] a, bit ws, logic [CNT_W-1:0] s,
                           bit wl, logic [CNT_W-1:0] l);
    cfg_reg_t    regs [3];
    logic [CNT_W-1:0] vals [3];
    bit          sel [3];
    regs = '{CFG_ALPHABET_SIZE, CFG_START_OFFSET, CFG_PATTERN_LENGTH};
    vals = '{CNT_W'(a), s, l};
    sel  = '{wa, ws, wl};
    for (int k = 0; k < 3; k++) begin
      if (sel[k]) begin
        cfg_if.valid <= 1'b1;
        cfg_if.index <= regs[k];
        cfg_if.data  <= vals[k];
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        case (regs[k])
          CFG_ALPHABET_SIZE:  alpha_reg  = vals[k][ALPHA_W-1:0];
          CFG_START_OFFSET:   skip_reg   = vals[k];
          CFG_PATTERN_LENGTH: length_reg = vals[k];
          default: ;
        endcase
      end
    end
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : stimulus
    bit wa, ws, wl;
    logic [ALPHA_W-1:0] a;
    logic [CNT_W-1:0] s, l;
    int k, len, pick;

    // Known levels on every input from time zero
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.mode = MODE_LOAD;
    in_if.charset_index = '0;
    in_if.charset_char = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_ALPHABET_SIZE;
    cfg_if.data = '0;

    // Walker reset: default registers, letters then digits
    alpha_reg  = ALPHA_RST;
    skip_reg   = OFFSET_RST;
    length_reg = PAT_LEN_RST;
    for (int i = 0; i < MAX_ALPHABET; i++) begin
      if (i < 26)      charset_mem[i] = CHAR_W'(8'h41 + i);
      else if (i < 52) charset_mem[i] = CHAR_W'(8'h61 + i - 26);
      else if (i < 61) charset_mem[i] = CHAR_W'(8'h31 + i - 52);
      else if (i == 61) charset_mem[i] = 8'h30;
      else             charset_mem[i] = 8'h00;
    end
    rewind_walker();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults, zero and all-ones charset bytes, an ignored mode, restart
    queue_req(MODE_NEXT);
    queue_req(MODE_NEXT);
    queue_req(MODE_LOAD, 6'd0, 8'h00);
    queue_req(MODE_LOAD, 6'd63, 8'hFF);
    queue_req(MODE_UNUSED, 6'h3F, 8'hFF);
    queue_req(MODE_RESTART);
    queue_req(MODE_NEXT);
    wait_idle();

    // Zero alphabet, zero length: exhausted at once
    configure(1'b1, 7'd0, 1'b0, '0, 1'b1, '0);
    queue_req(MODE_NEXT);
    wait_idle();

    // Oversized alphabet, short skip, length two: last flag then exhaustion
    configure(1'b1, 7'd127, 1'b1, 21'd3, 1'b1, 21'd2);
    queue_req(MODE_RESTART);
    repeat (3) queue_req(MODE_NEXT);
    wait_idle();

    // Binary alphabet, whole sequence shorter than the length
    configure(1'b1, 7'd2, 1'b1, '0, 1'b1, CNT_W'(COUNT_MAX));
    queue_req(MODE_RESTART);
    repeat (9) queue_req(MODE_NEXT);
    wait_idle();

    // Skip past the end of a one-symbol sequence
    configure(1'b1, 7'd1, 1'b1, CNT_W'(COUNT_MAX), 1'b0, '0);
    queue_req(MODE_RESTART);
    queue_req(MODE_NEXT);
    wait_idle();

    // Random phases: new settings, mostly restart then requests, some noise
    while (n_items < ITEM_TARGET) begin
      wa = 1'($urandom_range(0, 1));
      ws = 1'($urandom_range(0, 1));
      wl = 1'($urandom_range(0, 1));
      if (!(wa || ws || wl)) wa = 1'b1;
      a = alpha_reg;
      if (wa) begin
        case ($urandom_range(0, 9))
          0: a = 7'd1;
          1: a = 7'd2;
          2: a = 7'd3;
          3: a = ALPHA_W'($urandom_range(4, 8));
          4: a = 7'd64;
          5: a = 7'd0;
          6: a = 7'd127;
          7: a = ALPHA_W'($urandom_range(65, 127));
          default: a = ALPHA_W'($urandom_range(1, 64));
        endcase
      end
      k = symbols_of(a);
      // Keep restarts on wide alphabets short
      if (k > 12 && skip_reg > 1500) ws = 1'b1;
      s = skip_reg;
      if (ws) begin
        pick = $urandom_range(0, 5);
        if (k <= 12 && pick == 0)      s = CNT_W'(COUNT_MAX);
        else if (k <= 12 && pick == 1) s = CNT_W'($urandom_range(0, COUNT_MAX));
        else if (k <= 12)              s = CNT_W'($urandom_range(0, k * k * k + 2));
        else if (pick == 0)            s = CNT_W'($urandom_range(0, 1500));
        else                           s = CNT_W'($urandom_range(0, 200));
      end
      l = length_reg;
      if (wl) begin
        case ($urandom_range(0, 7))
          0: l = '0;
          1: l = 21'd1;
          2: l = CNT_W'($urandom_range(2, 40));
          3: l = CNT_W'($urandom_range(41, 3000));
          4: l = CNT_W'(COUNT_MAX);
          5: l = CNT_W'($urandom_range(0, COUNT_MAX));
          default: l = CNT_W'($urandom_range(20, 400));
        endcase
      end
      configure(wa, a, ws, s, wl, l);

      idle_on = (n_items < CALM_FROM) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 6) queue_req(MODE_RESTART);
      len = $urandom_range(15, 70);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 8)
          queue_req(MODE_LOAD, SYM_W'($urandom_range(0, 63)),
                    CHAR_W'($urandom_range(0, 255)));
        else if (pick < 11)
          queue_req(MODE_RESTART, SYM_W'($urandom_range(0, 63)),
                    CHAR_W'($urandom_range(0, 255)));
        else if (pick < 13)
          queue_req(MODE_UNUSED, SYM_W'($urandom_range(0, 63)),
                    CHAR_W'($urandom_range(0, 255)));
        else
          queue_req(MODE_NEXT, SYM_W'($urandom_range(0, 63)),
                    CHAR_W'($urandom_range(0, 255)));
      end
      // Close the phase with a request whose result marks the block idle
      queue_req(MODE_NEXT);
      wait_idle();
      n_phases++;
    end

    $display("Run covered %0d requests in %0d random phases plus directed cases;", n_items,
             n_phases);
    $display("%0d characters checked, %0d exhausted replies, %0d final-character flags.",
             n_chars, n_exh, n_last);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
